>>> rtl/core/tkts_pkg.sv
package tkts_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] CSI_INTRO  = 8'h5b;
  localparam logic [7:0] SS3_INTRO  = 8'h4f;
  localparam logic [7:0] ASCII_MAX  = 8'h7f;
  localparam logic [7:0] PARAM_LO   = 8'h30;
  localparam logic [7:0] PARAM_HI   = 8'h3f;
  localparam logic [7:0] INTER_LO   = 8'h20;
  localparam logic [7:0] INTER_HI   = 8'h2f;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7e;
  localparam logic [2:0] LEAD2_MARK = 3'b110;
  localparam logic [3:0] LEAD3_MARK = 4'b1110;
  localparam logic [4:0] LEAD4_MARK = 5'b11110;

  localparam int QUEUE_DEPTH = 3;
  localparam int OUT_DEPTH   = 4;
  localparam int HELD_DEPTH  = 3;

  typedef struct packed {
    logic load;
    logic step;
    logic drain;
  } tkts_cmd_t;

  typedef struct packed {
    logic step_last;
    logic has_out;
    logic drain_last;
  } tkts_status_t;

endpackage

>>> rtl/core/terminal_key_token_splitter.sv
// channel  signals                        direction  accepted when
// input    in_byte, burst_end             in         in_valid && in_ready
// output   token_byte, token_end, last    out        out_valid && out_ready
//
// one item at a time: the byte is taken, then each parsed byte is stepped in turn
// (the item's byte, plus each held utf-8 byte replayed after a cut-off lead),
// then the results are sent while out_ready is high; items with no result skip it
// rst is synchronous and clears the parser to idle with no token open
// a stall on out_ready holds the current result and keeps in_ready low
module terminal_key_token_splitter import tkts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       burst_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] token_byte,
  output logic       token_end,
  output logic       last
);

  tkts_cmd_t    cmd;
  tkts_status_t status;

  tkts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tkts_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_byte    (in_byte),
    .burst_end  (burst_end),
    .status     (status),
    .token_byte (token_byte),
    .token_end  (token_end),
    .last       (last)
  );

endmodule

>>> rtl/core/tkts_ctrl.sv
module tkts_ctrl import tkts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  tkts_status_t status,
  output tkts_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN
  } state_t;

  state_t state;

  assign cmd.load  = in_valid && in_ready;
  assign cmd.step  = (state == ST_FEED);
  assign cmd.drain = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_FEED;
            in_ready <= 1'b0;
          end
        end
        ST_FEED: begin
          if (status.step_last) begin
            if (status.has_out) begin
              state     <= ST_DRAIN;
              out_valid <= 1'b1;
            end else begin
              state    <= ST_IDLE;
              in_ready <= 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (out_valid && out_ready && status.drain_last) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= ST_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/tkts_datapath.sv
module tkts_datapath import tkts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tkts_cmd_t    cmd,
  input  logic [7:0]   in_byte,
  input  logic         burst_end,
  output tkts_status_t status,
  output logic [7:0]   token_byte,
  output logic         token_end,
  output logic         last
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_ESC,
    M_SS3,
    M_CSI,
    M_UTF8
  } mode_t;

  // parse state
  mode_t       mode, mode_next;
  logic        csi_phase, csi_phase_next;
  logic [7:0]  held [HELD_DEPTH];
  logic [7:0]  held_next [HELD_DEPTH];
  logic [1:0]  held_count, held_count_next;
  logic [1:0]  utf8_needed, utf8_needed_next;
  logic [7:0]  pending_byte, pending_byte_next;

  // byte queue for one item
  logic [7:0]  q [QUEUE_DEPTH];
  logic [1:0]  qn;
  logic [1:0]  qi;
  logic        burst;

  // result buffer
  logic [7:0]  obuf_b [OUT_DEPTH];
  logic        obuf_e [OUT_DEPTH];
  logic [2:0]  out_n, out_n_next;
  logic [1:0]  rd;

  // step logic
  logic [7:0]  b;
  logic        e;
  logic        st_emit;
  logic        st_e;
  mode_t       st_mode;
  logic [1:0]  st_need;
  logic        par, inter, fin;
  logic [1:0]  hc;
  logic [7:0]  em_b [OUT_DEPTH];
  logic        em_e [OUT_DEPTH];
  logic [2:0]  ec;
  logic [7:0]  rq [QUEUE_DEPTH];
  logic [1:0]  rn;
  logic [3:0]  sum;

  assign b = q[qi];
  assign e = burst && (qi == qn - 2'd1);

  // token start for the current byte
  always_comb begin
    st_need = 2'd0;
    if (b[7:5] == LEAD2_MARK) st_need = 2'd1;
    else if (b[7:4] == LEAD3_MARK) st_need = 2'd2;
    else if (b[7:3] == LEAD4_MARK) st_need = 2'd3;
    st_emit = 1'b1;
    st_e    = 1'b1;
    st_mode = M_IDLE;
    if (b == ESC_BYTE) begin
      st_e = e;
      if (!e) st_mode = M_ESC;
    end else if (b > ASCII_MAX && st_need != 2'd0 && !e) begin
      st_emit = 1'b0;
      st_mode = M_UTF8;
    end
  end

  assign par   = (b >= PARAM_LO) && (b <= PARAM_HI) && !csi_phase;
  assign inter = (b >= INTER_LO) && (b <= INTER_HI);
  assign fin   = (b >= FINAL_LO) && (b <= FINAL_HI);
  assign hc    = (held_count == 2'd0) ? 2'd1 : held_count;

  always_comb begin
    mode_next         = mode;
    csi_phase_next    = csi_phase;
    held_count_next   = held_count;
    utf8_needed_next  = utf8_needed;
    pending_byte_next = pending_byte;
    for (int i = 0; i < HELD_DEPTH; i++) held_next[i] = held[i];
    for (int i = 0; i < OUT_DEPTH; i++) begin
      em_b[i] = b;
      em_e[i] = 1'b0;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) rq[i] = b;
    ec = 3'd0;
    rn = 2'd0;

    case (mode)
      M_ESC: begin
        mode_next = M_IDLE;
        if (b == CSI_INTRO) begin
          if (e) begin
            em_e[0] = 1'b1;
            ec      = 3'd1;
          end else begin
            pending_byte_next = b;
            csi_phase_next    = 1'b0;
            mode_next         = M_CSI;
          end
        end else if (b == SS3_INTRO && !e) begin
          ec        = 3'd1;
          mode_next = M_SS3;
        end else begin
          em_e[0] = 1'b1;
          ec      = 3'd1;
        end
      end
      M_SS3: begin
        em_e[0]   = 1'b1;
        ec        = 3'd1;
        mode_next = M_IDLE;
      end
      M_CSI: begin
        em_b[0] = pending_byte;
        if (par || inter || fin) begin
          if (fin || e) begin
            em_e[1]        = 1'b1;
            ec             = 3'd2;
            csi_phase_next = 1'b0;
            mode_next      = M_IDLE;
          end else begin
            ec                = 3'd1;
            pending_byte_next = b;
            if (inter) csi_phase_next = 1'b1;
          end
        end else begin
          em_e[0]        = 1'b1;
          csi_phase_next = 1'b0;
          mode_next      = st_mode;
          em_e[1]        = st_e;
          ec             = st_emit ? 3'd2 : 3'd1;
          if (st_mode == M_UTF8) begin
            held_next[0]     = b;
            held_count_next  = 2'd1;
            utf8_needed_next = st_need;
          end
        end
      end
      M_UTF8: begin
        if (utf8_needed <= 2'd1) begin
          for (int i = 0; i < HELD_DEPTH; i++) begin
            if (2'(i) < hc) em_b[i] = held[i];
          end
          em_b[hc]         = b;
          em_e[hc]         = 1'b1;
          ec               = {1'b0, hc} + 3'd1;
          utf8_needed_next = 2'd0;
          held_count_next  = 2'd0;
          mode_next        = M_IDLE;
        end else if (e) begin
          em_b[0] = held[0];
          em_e[0] = 1'b1;
          ec      = 3'd1;
          for (int i = 1; i < HELD_DEPTH; i++) begin
            if (2'(i) < hc) rq[i - 1] = held[i];
          end
          rq[hc - 2'd1]    = b;
          rn               = hc;
          utf8_needed_next = 2'd0;
          held_count_next  = 2'd0;
          mode_next        = M_IDLE;
        end else begin
          if (hc < 2'd3) begin
            held_next[hc]   = b;
            held_count_next = hc + 2'd1;
          end else begin
            held_count_next = hc;
          end
          utf8_needed_next = utf8_needed - 2'd1;
        end
      end
      default: begin
        mode_next = st_mode;
        em_e[0]   = st_e;
        ec        = st_emit ? 3'd1 : 3'd0;
        if (st_mode == M_UTF8) begin
          held_next[0]     = b;
          held_count_next  = 2'd1;
          utf8_needed_next = st_need;
        end
      end
    endcase

    sum = {1'b0, out_n} + {1'b0, ec};
    out_n_next = (sum > 4'(OUT_DEPTH)) ? 3'(OUT_DEPTH) : sum[2:0];
  end

  assign status.step_last  = (rn == 2'd0) && (qi == qn - 2'd1);
  assign status.has_out    = (out_n_next != 3'd0);
  assign status.drain_last = ({1'b0, rd} == out_n - 3'd1);

  assign token_byte = obuf_b[rd];
  assign token_end  = obuf_e[rd];
  assign last       = status.drain_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      csi_phase    <= 1'b0;
      held_count   <= 2'd0;
      utf8_needed  <= 2'd0;
      pending_byte <= 8'd0;
      out_n        <= 3'd0;
      rd           <= 2'd0;
      qn           <= 2'd1;
      qi           <= 2'd0;
    end else if (cmd.load) begin
      q[0]  <= in_byte;
      burst <= burst_end;
      qn    <= 2'd1;
      qi    <= 2'd0;
      out_n <= 3'd0;
      rd    <= 2'd0;
    end else if (cmd.step) begin
      mode         <= mode_next;
      csi_phase    <= csi_phase_next;
      held_count   <= held_count_next;
      utf8_needed  <= utf8_needed_next;
      pending_byte <= pending_byte_next;
      for (int i = 0; i < HELD_DEPTH; i++) held[i] <= held_next[i];
      for (int j = 0; j < OUT_DEPTH; j++) begin
        for (int k = 0; k < OUT_DEPTH; k++) begin
          if ((3'(k) < ec) && ({1'b0, out_n} + 4'(k) == 4'(j))) begin
            obuf_b[j] <= em_b[k];
            obuf_e[j] <= em_e[k];
          end
        end
      end
      out_n <= out_n_next;
      if (rn != 2'd0) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) q[i] <= rq[i];
        qn <= rn;
        qi <= 2'd0;
      end else begin
        qi <= qi + 2'd1;
      end
    end else if (cmd.drain) begin
      rd <= rd + 2'd1;
    end
  end

endmodule
